// File: src/tsm_pkg.sv
// Shared types, command codes and status codes for the top-k score merge block.
package tsm_pkg;

    typedef logic [31:0] word_t;
    typedef logic [63:0] prod_t;
    typedef logic [55:0] score_t;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_SETUP = 2'd1;
    localparam cmd_t CMD_SCORE = 2'd2;
    localparam cmd_t CMD_BOUND = 2'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_SAT   = 2'd2;

    localparam int FREQ_W      = 24;
    localparam int NORM_W      = 8;
    localparam int NORM_LEVELS = 256;

endpackage

// File: src/tsm_mult.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
module tsm_mult
(
    input  logic           clk,
    input  tsm_pkg::word_t a,
    input  tsm_pkg::word_t b,
    output tsm_pkg::prod_t prod
);

    tsm_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= tsm_pkg::prod_t'(a) * tsm_pkg::prod_t'(b);
    end

    assign prod = prod_reg;

endmodule

// File: src/topk_score_merge.sv
// Top level: per-query top-k score keeper built on min-heaps, one shared multiplier.
// Work per command between acceptance and m_tvalid: load and set up go straight to the result;
// a bound read does two multiplies (none on an empty heap); a score does one multiply and is
// refused at once by a zero limit, or by a full heap after a compare with the root. An insert
// sifts up a level at a time; a replace sifts down a level at a time from the root.
// Throughput: one transaction at a time; s_tready returns when the result is registered.
// Reset (rst_n, asynchronous, active low) clears limits, quant factors and heap counts.
module topk_score_merge
#(
    parameter int NUM_QUERIES = 8,
    parameter int MAX_K       = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: query[2:0], norm_index[10:3], value[42:11], top_k[49:43],
    // packed_score[81:50], zero fill.
    input  logic [87:0] s_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: min_bound[31:0], held_count[38:32], accepted[39],
    // status[41:40], zero fill.
    output logic [47:0] m_tdata
);

    localparam int QW = (NUM_QUERIES > 1) ? $clog2(NUM_QUERIES) : 1;
    localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FIN     = 4'd1;
    localparam logic [3:0] S_NRD     = 4'd2;
    localparam logic [3:0] S_SMUL    = 4'd3;
    localparam logic [3:0] S_SCHK    = 4'd4;
    localparam logic [3:0] S_INS_UP  = 4'd5;
    localparam logic [3:0] S_INS_CMP = 4'd6;
    localparam logic [3:0] S_REP_CHK = 4'd7;
    localparam logic [3:0] S_DN_HEAD = 4'd8;
    localparam logic [3:0] S_DN_L    = 4'd9;
    localparam logic [3:0] S_DN_R    = 4'd10;
    localparam logic [3:0] S_BRD     = 4'd11;
    localparam logic [3:0] S_BLO     = 4'd12;
    localparam logic [3:0] S_BHI     = 4'd13;
    localparam logic [3:0] S_BFIN    = 4'd14;

    // Input fields of the current transaction.
    logic [2:0]      in_query;
    logic [7:0]      in_norm;
    tsm_pkg::word_t  in_value;
    logic [6:0]      in_topk;
    tsm_pkg::word_t  in_packed;
    tsm_pkg::cmd_t   in_cmd;
    logic            in_range;
    logic            accept;

    assign in_query  = s_tdata[2:0];
    assign in_norm   = s_tdata[10:3];
    assign in_value  = s_tdata[42:11];
    assign in_topk   = s_tdata[49:43];
    assign in_packed = s_tdata[81:50];
    assign in_cmd    = s_tuser;
    assign in_range  = 32'(in_query) < NUM_QUERIES;

    // Sequencer registers.
    logic [3:0]       state_reg, state_next;
    logic [QW-1:0]    q_reg, q_next;
    logic             rng_reg, rng_next;
    tsm_pkg::word_t   packed_reg, packed_next;
    tsm_pkg::score_t  v_reg, v_next;
    tsm_pkg::score_t  hl_reg, hl_next;
    logic [KW-1:0]    i_reg, i_next;
    tsm_pkg::word_t   bound_reg, bound_next;
    logic             acc_reg, acc_next;
    tsm_pkg::status_t stat_reg, stat_next;
    logic             sat_reg, sat_next;
    logic             mvalid_reg, mvalid_next;
    logic [47:0]      mdata_reg, mdata_next;

    // Per-query registers.
    logic [CW-1:0]   count_reg [NUM_QUERIES];
    logic [CW-1:0]   limit_reg [NUM_QUERIES];
    tsm_pkg::word_t  quant_reg [NUM_QUERIES];

    // Memories.
    tsm_pkg::word_t  norm_mem [NUM_QUERIES][tsm_pkg::NORM_LEVELS];
    tsm_pkg::score_t heap_mem [NUM_QUERIES][MAX_K];
    tsm_pkg::word_t  norm_rd;
    tsm_pkg::score_t heap_rd;

    logic            heap_we;
    logic [KW-1:0]   heap_widx;
    tsm_pkg::score_t heap_wdata;
    logic [KW-1:0]   heap_ridx;
    logic            cnt_inc;

    tsm_pkg::word_t  mul_a, mul_b;
    tsm_pkg::prod_t  prod;

    logic [CW-1:0]   cnt_cur;
    logic [CW-1:0]   lim_cur;
    tsm_pkg::word_t  quant_cur;
    logic [CW:0]     l_w, r_w;
    logic [KW-1:0]   parent;
    logic            take_l, take_r;
    tsm_pkg::score_t sv;
    logic [32:0]     bsum;

    assign cnt_cur   = count_reg[q_reg];
    assign lim_cur   = limit_reg[q_reg];
    assign quant_cur = quant_reg[q_reg];
    assign l_w       = (CW + 1)'({i_reg, 1'b1});
    assign r_w       = l_w + (CW + 1)'(1);
    assign parent    = (i_reg - KW'(1)) >> 1;

    // The bound is (high product << 16) plus the low product >> 16; this adds the part
    // of the high product that lands inside the 32-bit word.
    assign bsum = {1'b0, prod[15:0], 16'd0} + {1'b0, bound_reg};

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    tsm_mult u_mult
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        rng_next    = rng_reg;
        packed_next = packed_reg;
        v_next      = v_reg;
        hl_next     = hl_reg;
        i_next      = i_reg;
        bound_next  = bound_reg;
        acc_next    = acc_reg;
        stat_next   = stat_reg;
        sat_next    = sat_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        heap_we     = 1'b0;
        heap_widx   = i_reg;
        heap_wdata  = v_reg;
        heap_ridx   = '0;
        cnt_inc     = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        take_l      = hl_reg < v_reg;
        sv          = take_l ? hl_reg : v_reg;
        take_r      = heap_rd < sv;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    q_next      = QW'(in_query);
                    rng_next    = in_range;
                    packed_next = in_packed;
                    bound_next  = '0;
                    acc_next    = 1'b0;
                    stat_next   = tsm_pkg::STATUS_OK;
                    if (!in_range)
                        state_next = S_FIN;
                    else
                    begin
                        unique case (in_cmd)
                            tsm_pkg::CMD_LOAD:  state_next = S_FIN;
                            tsm_pkg::CMD_SETUP: state_next = S_FIN;
                            tsm_pkg::CMD_SCORE: state_next = S_NRD;
                            tsm_pkg::CMD_BOUND: state_next = S_BRD;
                            default:            state_next = S_FIN;
                        endcase
                    end
                end
            end
            S_NRD:
            begin
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                mul_a      = norm_rd;
                mul_b      = 32'(packed_reg[tsm_pkg::FREQ_W-1:0]);
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                v_next = prod[55:0];
                if (cnt_cur < lim_cur)
                begin
                    i_next     = KW'(cnt_cur);
                    state_next = S_INS_UP;
                end
                else if (cnt_cur != '0)
                begin
                    heap_ridx  = '0;
                    state_next = S_REP_CHK;
                end
                else
                    state_next = S_FIN;
            end
            S_INS_UP:
            begin
                if (i_reg == '0)
                begin
                    heap_we    = 1'b1;
                    cnt_inc    = 1'b1;
                    acc_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    heap_ridx  = parent;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                heap_we = 1'b1;
                if (heap_rd <= v_reg)
                begin
                    cnt_inc    = 1'b1;
                    acc_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    heap_wdata = heap_rd;
                    i_next     = parent;
                    state_next = S_INS_UP;
                end
            end
            S_REP_CHK:
            begin
                if (v_reg > heap_rd)
                begin
                    i_next     = '0;
                    state_next = S_DN_HEAD;
                end
                else
                    state_next = S_FIN;
            end
            S_DN_HEAD:
            begin
                if (l_w < (CW + 1)'(cnt_cur))
                begin
                    heap_ridx  = KW'(l_w);
                    state_next = S_DN_L;
                end
                else
                begin
                    heap_we    = 1'b1;
                    acc_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN_L:
            begin
                hl_next = heap_rd;
                if (r_w < (CW + 1)'(cnt_cur))
                begin
                    heap_ridx  = KW'(r_w);
                    state_next = S_DN_R;
                end
                else
                begin
                    heap_we = 1'b1;
                    if (heap_rd < v_reg)
                    begin
                        heap_wdata = heap_rd;
                        i_next     = KW'(l_w);
                        state_next = S_DN_HEAD;
                    end
                    else
                    begin
                        acc_next   = 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_DN_R:
            begin
                // Smallest of the sifting value and both children moves up.
                heap_we = 1'b1;
                if (take_r)
                begin
                    heap_wdata = heap_rd;
                    i_next     = KW'(r_w);
                    state_next = S_DN_HEAD;
                end
                else if (take_l)
                begin
                    heap_wdata = hl_reg;
                    i_next     = KW'(l_w);
                    state_next = S_DN_HEAD;
                end
                else
                begin
                    acc_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_BRD:
            begin
                if (cnt_cur == '0)
                begin
                    stat_next  = tsm_pkg::STATUS_EMPTY;
                    state_next = S_FIN;
                end
                else
                begin
                    heap_ridx  = '0;
                    state_next = S_BLO;
                end
            end
            S_BLO:
            begin
                v_next     = heap_rd;
                mul_a      = heap_rd[31:0];
                mul_b      = quant_cur;
                state_next = S_BHI;
            end
            S_BHI:
            begin
                // Low partial product; its bits above 47 already mean overflow.
                bound_next = prod[47:16];
                sat_next   = |prod[63:48];
                mul_a      = 32'(v_reg[55:32]);
                mul_b      = quant_cur;
                state_next = S_BFIN;
            end
            S_BFIN:
            begin
                // High partial product bits from 16 up land above the 32-bit word.
                if (sat_reg || (|prod[63:16]) || bsum[32])
                begin
                    bound_next = '1;
                    stat_next  = tsm_pkg::STATUS_SAT;
                end
                else
                    bound_next = bsum[31:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {6'd0, stat_reg, acc_reg,
                                   rng_reg ? 7'(cnt_cur) : 7'd0, bound_reg};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            for (int k = 0; k < NUM_QUERIES; k++)
            begin
                count_reg[k] <= '0;
                limit_reg[k] <= '0;
                quant_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            if (accept && in_range && (in_cmd == tsm_pkg::CMD_SETUP))
            begin
                limit_reg[QW'(in_query)] <= (32'(in_topk) > MAX_K) ? CW'(MAX_K)
                                                                    : CW'(in_topk);
                quant_reg[QW'(in_query)] <= in_value;
                count_reg[QW'(in_query)] <= '0;
            end
            else if (cnt_inc)
                count_reg[q_reg] <= cnt_cur + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        rng_reg    <= rng_next;
        packed_reg <= packed_next;
        v_reg      <= v_next;
        hl_reg     <= hl_next;
        i_reg      <= i_next;
        bound_reg  <= bound_next;
        acc_reg    <= acc_next;
        stat_reg   <= stat_next;
        sat_reg    <= sat_next;
        mdata_reg  <= mdata_next;
    end

    // Norm weight table: written by load transactions, read for the score multiply.
    always_ff @(posedge clk)
    begin
        if (accept && in_range && (in_cmd == tsm_pkg::CMD_LOAD))
            norm_mem[QW'(in_query)][in_norm] <= in_value;
        norm_rd <= norm_mem[q_reg][packed_reg[tsm_pkg::FREQ_W +: tsm_pkg::NORM_W]];
    end

    // Heap store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[q_reg][heap_widx] <= heap_wdata;
        heap_rd <= heap_mem[q_reg][heap_ridx];
    end

endmodule

// File: verif/topk_score_merge_tb.sv
// Testbench for topk_score_merge: directed and random command streams checked against a min-heap predictor.
module topk_score_merge_tb;

    localparam int NQ      = 8;
    localparam int KMAX    = 64;
    localparam int N_RAND  = 1700;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0]      bound;
        logic [6:0]       held;
        logic             acc;
        tsm_pkg::status_t status;
    } answer_t;

    // Scoreboard: keeps its own copy of the norm tables, limits, quant factors and
    // heaps, and a queue of answers that the block still owes.
    class topk_scoreboard;
        tsm_pkg::word_t  weights [NQ][tsm_pkg::NORM_LEVELS];
        bit              loaded  [NQ][tsm_pkg::NORM_LEVELS];
        int              limit   [NQ];
        tsm_pkg::word_t  quant   [NQ];
        tsm_pkg::score_t heap    [NQ][KMAX];
        int              count   [NQ];
        answer_t         owed[$];
        int              errors;
        int              checked;

        function void clear();
            for (int q = 0; q < NQ; q++)
            begin
                limit[q] = 0;
                quant[q] = '0;
                count[q] = 0;
                for (int n = 0; n < tsm_pkg::NORM_LEVELS; n++)
                    loaded[q][n] = 1'b0;
            end
            owed.delete();
            errors  = 0;
            checked = 0;
        endfunction

        // Sift a new value up from slot n.
        function void push_up(int q, int n, tsm_pkg::score_t v);
            int i;
            int p;
            i = n;
            while (i > 0)
            begin
                p = (i - 1) / 2;
                if (heap[q][p] <= v)
                    break;
                heap[q][i] = heap[q][p];
                i = p;
            end
            heap[q][i] = v;
        endfunction

        // Put a value at the root and sift it down.
        function void swap_root(int q, tsm_pkg::score_t v);
            int i;
            int l;
            int s;
            tsm_pkg::score_t sv;
            i = 0;
            forever
            begin
                l  = 2 * i + 1;
                s  = i;
                sv = v;
                if (l < count[q] && heap[q][l] < sv)
                begin
                    s  = l;
                    sv = heap[q][l];
                end
                if (l + 1 < count[q] && heap[q][l + 1] < sv)
                    s = l + 1;
                if (s == i)
                    break;
                heap[q][i] = heap[q][s];
                i = s;
            end
            heap[q][i] = v;
        endfunction

        function void note_input(tsm_pkg::cmd_t cmd, int q, int nidx, tsm_pkg::word_t value,
                                 int topk, tsm_pkg::word_t packed_score);
            answer_t a;
            tsm_pkg::score_t sc;
            logic [95:0] prod;
            a = '0;
            case (cmd)
                tsm_pkg::CMD_LOAD:
                begin
                    weights[q][nidx] = value;
                    loaded[q][nidx]  = 1'b1;
                end
                tsm_pkg::CMD_SETUP:
                begin
                    limit[q] = (topk > KMAX) ? KMAX : topk;
                    quant[q] = value;
                    count[q] = 0;
                end
                tsm_pkg::CMD_SCORE:
                begin
                    sc = tsm_pkg::score_t'(64'(weights[q][packed_score[31:24]]) *
                                           64'(packed_score[23:0]));
                    if (count[q] < limit[q])
                    begin
                        push_up(q, count[q], sc);
                        count[q]++;
                        a.acc = 1'b1;
                    end
                    else if (count[q] > 0 && sc > heap[q][0])
                    begin
                        swap_root(q, sc);
                        a.acc = 1'b1;
                    end
                end
                default:
                begin
                    if (count[q] == 0)
                        a.status = tsm_pkg::STATUS_EMPTY;
                    else
                    begin
                        // The full product fits in 88 bits; the bound is its top part.
                        prod = 96'(heap[q][0]) * 96'(quant[q]);
                        prod = prod >> 16;
                        if (prod > 96'hFFFF_FFFF)
                        begin
                            a.bound  = 32'hFFFF_FFFF;
                            a.status = tsm_pkg::STATUS_SAT;
                        end
                        else
                            a.bound = prod[31:0];
                    end
                end
            endcase
            a.held = 7'(count[q]);
            owed.push_back(a);
        endfunction

        function void check_result(logic [47:0] d);
            answer_t e;
            if (owed.size() == 0)
            begin
                $error("result with no transaction outstanding: %h", d);
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            if (d[31:0] !== e.bound)
            begin
                $error("min_bound: expected %h, got %h", e.bound, d[31:0]);
                errors++;
            end
            if (d[38:32] !== e.held)
            begin
                $error("held_count: expected %0d, got %0d", e.held, d[38:32]);
                errors++;
            end
            if (d[39] !== e.acc)
            begin
                $error("accepted: expected %0b, got %0b", e.acc, d[39]);
                errors++;
            end
            if (d[41:40] !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, d[41:40]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    topk_scoreboard sb;
    longint cycles;
    bit     hold_off;     // Set by the stimulus to ask the receiver for a long stall.
    int     scores_sent;
    int     bound_reads;

    topk_score_merge u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Send one transaction: drive at the falling edge, wait for the handshake at a
    // rising edge, and note it in the scoreboard. Valid stays high across back to
    // back transactions; the caller lowers it for gaps.
    task automatic send_item(tsm_pkg::cmd_t cmd, int q, int nidx, tsm_pkg::word_t value,
                             int topk, tsm_pkg::word_t packed_score);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, packed_score, 7'(topk), value, 8'(nidx), 3'(q)};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(cmd, q, nidx, value, topk, packed_score);
        if (cmd == tsm_pkg::CMD_SCORE)
            scores_sent++;
        if (cmd == tsm_pkg::CMD_BOUND)
            bound_reads++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge clk);
    endtask

    // Score words use only norms that were loaded for the query, so that every
    // lookup reads a written table entry.
    function automatic tsm_pkg::word_t pick_score(int q);
        int n;
        do
            n = $urandom_range(255);
        while (!sb.loaded[q][n]);
        case ($urandom_range(3))
            0:       return {8'(n), 24'hFFFFFF};
            1:       return {8'(n), 24'($urandom_range(15))};
            default: return {8'(n), 24'($urandom)};
        endcase
    endfunction

    function automatic tsm_pkg::word_t pick_word();
        case ($urandom_range(4))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0001_0000;
            2:       return 32'($urandom_range(65535));
            default: return $urandom;
        endcase
    endfunction

    // Receiver: a stall pattern that switches at random, plus a long hold-off on request.
    initial
    begin
        int mode;
        int held;
        m_tready = 1'b0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < 200; held++)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            if (($urandom_range(63)) == 0)
                mode = $urandom_range(3);
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(3) != 0);
                2:       m_tready <= ($urandom_range(3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int q;
        int burst;
        int r;
        sb = new();
        sb.clear();
        cycles      = 0;
        hold_off    = 1'b0;
        scores_sent = 0;
        bound_reads = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = tsm_pkg::CMD_LOAD;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty reads, zero limit, extremes, saturation, ties.
        send_item(tsm_pkg::CMD_BOUND, 0, 0, 0, 0, 0);
        send_item(tsm_pkg::CMD_LOAD, 0, 255, 32'hFFFF_FFFF, 0, 0);
        send_item(tsm_pkg::CMD_LOAD, 0, 0, 32'h0001_0000, 0, 0);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'h00FF_FFFF);
        send_item(tsm_pkg::CMD_SETUP, 0, 0, 32'hFFFF_FFFF, 127, 0);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(tsm_pkg::CMD_BOUND, 0, 0, 0, 0, 0);
        send_item(tsm_pkg::CMD_SETUP, 0, 0, 32'h0001_0000, 2, 0);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'h0000_0005);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'h0000_0003);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'h0000_0003);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'h0000_0002);
        send_item(tsm_pkg::CMD_SCORE, 0, 0, 0, 0, 32'h0000_0009);
        send_item(tsm_pkg::CMD_BOUND, 0, 0, 0, 0, 0);
        send_item(tsm_pkg::CMD_LOAD, 7, 0, 32'h0000_0000, 0, 0);
        send_item(tsm_pkg::CMD_SETUP, 7, 255, 0, 64, 32'hFFFF_FFFF);
        send_item(tsm_pkg::CMD_SCORE, 7, 0, 0, 0, 32'h00FF_FFFF);
        send_item(tsm_pkg::CMD_BOUND, 7, 0, 0, 0, 0);
        send_item(tsm_pkg::CMD_SETUP, 7, 0, 32'h0000_0001, 1, 0);
        send_item(tsm_pkg::CMD_BOUND, 7, 0, 0, 0, 0);
        wait_drained();

        // Load a few norms per query so random scores have tables to use.
        for (q = 0; q < NQ; q++)
        begin
            for (r = 0; r < 6; r++)
                send_item(tsm_pkg::CMD_LOAD, q, $urandom_range(255), pick_word(), 0, 0);
            send_item(tsm_pkg::CMD_SETUP, q, 0, pick_word(), $urandom_range(70), 0);
        end

        // Random part: mostly scores into filling heaps, with reloads, fresh set ups
        // and bound reads mixed in, sent in bursts that are mostly separated by gaps.
        r = 0;
        while (r < N_RAND)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                q = $urandom_range(NQ - 1);
                case ($urandom_range(19))
                    0, 1:
                        send_item(tsm_pkg::CMD_LOAD, q, $urandom_range(255), pick_word(),
                                  $urandom_range(127), $urandom);
                    2:
                        send_item(tsm_pkg::CMD_SETUP, q, $urandom_range(255), pick_word(),
                                  ($urandom_range(9) == 0) ? $urandom_range(127)
                                                           : $urandom_range(64),
                                  $urandom);
                    3, 4, 5:
                        send_item(tsm_pkg::CMD_BOUND, q, $urandom_range(255), $urandom,
                                  $urandom_range(127), $urandom);
                    default:
                        send_item(tsm_pkg::CMD_SCORE, q, $urandom_range(255), $urandom,
                                  $urandom_range(127), pick_score(q));
                endcase
                r++;
            end
            if (r > 600 && r < 650)
            begin
                // The receiver stalls while the sender keeps offering items.
                hold_off = 1'b1;
            end
            if (r > 1100 && r < 1150)
                wait_drained();
            else if ($urandom_range(2) != 0)
                idle_cycles($urandom_range(1, 30));
        end

        wait_drained();
        repeat (60)
            @(negedge clk);
        $display("Covered %0d result checks: %0d scores and %0d bound reads over %0d queries.",
                 sb.checked, scores_sent, bound_reads, NQ);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
